>>> hw/rtl/dlpb_pkg.sv
`default_nettype none

package dlpb_pkg;

    // Width of each configuration time register and of the configuration write data.
    localparam int CFG_W = 16;

    // Index width of the configuration port.
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HINT        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG_PRESS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WAKE_LOCK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WOKE        = 3'd4;

    localparam logic [CFG_W-1:0] RST_DEBOUNCE_MS   = 16'd50;
    localparam logic [CFG_W-1:0] RST_HINT_MS       = 16'd1500;
    localparam logic [CFG_W-1:0] RST_LONG_PRESS_MS = 16'd3000;
    localparam logic [CFG_W-1:0] RST_WAKE_LOCK_MS  = 16'd3000;

    // Item function codes.
    localparam logic FUNC_TICK       = 1'b0;
    localparam logic FUNC_SET_COLOUR = 1'b1;

    // Colours are {red, green, blue}.
    localparam logic [2:0] COLOUR_OFF = 3'b000;
    localparam logic [2:0] COLOUR_RED = 3'b100;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] hint_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] wake_lockout_ms;
        logic             woke_from_sleep;
    } t_cfg;

    typedef struct packed {
        logic       func;
        logic       button_level;
        logic [2:0] colour;
    } t_item;

    typedef struct packed {
        logic [2:0] colour;
        logic       hint_active;
        logic       shutdown_request;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/dlpb_in_if.sv
`default_nettype none

interface dlpb_in_if;
    logic valid;
    logic ready;
    logic func;
    logic button_level;
    logic red_on;
    logic green_on;
    logic blue_on;

    modport source (
        output valid, func, button_level, red_on, green_on, blue_on,
        input  ready
    );

    modport sink (
        input  valid, func, button_level, red_on, green_on, blue_on,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/dlpb_out_if.sv
`default_nettype none

interface dlpb_out_if;
    logic valid;
    logic ready;
    logic led_red;
    logic led_green;
    logic led_blue;
    logic hint_active;
    logic shutdown_request;

    modport source (
        output valid, led_red, led_green, led_blue, hint_active, shutdown_request,
        input  ready
    );

    modport sink (
        input  valid, led_red, led_green, led_blue, hint_active, shutdown_request,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/dlpb_cfg_regs.sv
`default_nettype none

module dlpb_cfg_regs
    import dlpb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_idx,
    input  logic [CFG_W-1:0]     i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms     <= RST_DEBOUNCE_MS;
            r_cfg.hint_ms         <= RST_HINT_MS;
            r_cfg.long_press_ms   <= RST_LONG_PRESS_MS;
            r_cfg.wake_lockout_ms <= RST_WAKE_LOCK_MS;
            r_cfg.woke_from_sleep <= 1'b0;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_IDX_DEBOUNCE:   r_cfg.debounce_ms     <= i_data;
                CFG_IDX_HINT:       r_cfg.hint_ms         <= i_data;
                CFG_IDX_LONG_PRESS: r_cfg.long_press_ms   <= i_data;
                CFG_IDX_WAKE_LOCK:  r_cfg.wake_lockout_ms <= i_data;
                CFG_IDX_WOKE:       r_cfg.woke_from_sleep <= i_data[0];
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> hw/rtl/dlpb_state.sv
`default_nettype none

module dlpb_state
    import dlpb_pkg::*;
#(
    parameter int TIME_WIDTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int TW    = TIME_WIDTH;
    localparam int CMP_W = (TW > CFG_W) ? TW : CFG_W;

    logic          r_prev_sample;
    logic [TW-1:0] r_since_edge;
    logic          r_pressed;
    logic [TW-1:0] r_held_time;
    logic          r_hint;
    logic [TW-1:0] r_since_start;
    logic          r_shutdown;
    logic [2:0]    r_status_colour;
    logic [2:0]    r_shown_colour;

    logic          n_prev_sample;
    logic [TW-1:0] n_since_edge;
    logic          n_pressed;
    logic [TW-1:0] n_held_time;
    logic          n_hint;
    logic [TW-1:0] n_since_start;
    logic          n_shutdown;
    logic [2:0]    n_status_colour;
    logic [2:0]    n_shown_colour;

    logic          level;
    logic          debounced;
    logic          locked_out;

    function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
        return (&v) ? v : v + TW'(1);
    endfunction

    always_comb begin
        n_prev_sample   = r_prev_sample;
        n_since_edge    = r_since_edge;
        n_pressed       = r_pressed;
        n_held_time     = r_held_time;
        n_hint          = r_hint;
        n_since_start   = r_since_start;
        n_shutdown      = r_shutdown;
        n_status_colour = r_status_colour;
        n_shown_colour  = r_shown_colour;
        level           = i_item.button_level;
        debounced       = 1'b0;
        locked_out      = 1'b0;

        if (i_item.func == FUNC_SET_COLOUR) begin
            n_status_colour = i_item.colour;
            if (!r_shutdown && !r_hint) begin
                n_shown_colour = i_item.colour;
            end
        end else if (!r_shutdown) begin
            n_since_start = sat_inc(r_since_start);
            if (level != r_prev_sample) begin
                n_prev_sample = level;
                n_since_edge  = '0;
            end else begin
                n_since_edge = sat_inc(r_since_edge);
            end
            if (r_pressed) begin
                n_held_time = sat_inc(r_held_time);
            end

            debounced  = CMP_W'(n_since_edge) >= CMP_W'(i_cfg.debounce_ms);
            locked_out = i_cfg.woke_from_sleep &&
                         (CMP_W'(n_since_start) < CMP_W'(i_cfg.wake_lockout_ms));

            if (debounced) begin
                if (locked_out) begin
                    n_pressed = 1'b0;
                end else begin
                    // A fresh press restarts the hold timer and drops any stale hint.
                    if (level && !r_pressed) begin
                        n_pressed   = 1'b1;
                        n_held_time = '0;
                        if (r_hint) begin
                            n_hint         = 1'b0;
                            n_shown_colour = r_status_colour;
                        end
                    end else if (!level && r_pressed) begin
                        n_pressed = 1'b0;
                    end

                    if (n_pressed) begin
                        if (!n_hint &&
                            (CMP_W'(n_held_time) >= CMP_W'(i_cfg.hint_ms))) begin
                            n_hint         = 1'b1;
                            n_shown_colour = COLOUR_RED;
                        end
                        if (CMP_W'(n_held_time) >= CMP_W'(i_cfg.long_press_ms)) begin
                            n_shutdown     = 1'b1;
                            n_shown_colour = COLOUR_OFF;
                        end
                    end else if (n_hint) begin
                        n_hint         = 1'b0;
                        n_shown_colour = r_status_colour;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sample   <= 1'b0;
            r_since_edge    <= '1;
            r_pressed       <= 1'b0;
            r_held_time     <= '0;
            r_hint          <= 1'b0;
            r_since_start   <= '0;
            r_shutdown      <= 1'b0;
            r_status_colour <= COLOUR_OFF;
            r_shown_colour  <= COLOUR_OFF;
        end else if (i_fire) begin
            r_prev_sample   <= n_prev_sample;
            r_since_edge    <= n_since_edge;
            r_pressed       <= n_pressed;
            r_held_time     <= n_held_time;
            r_hint          <= n_hint;
            r_since_start   <= n_since_start;
            r_shutdown      <= n_shutdown;
            r_status_colour <= n_status_colour;
            r_shown_colour  <= n_shown_colour;
        end
    end

    assign o_result.colour           = n_shown_colour;
    assign o_result.hint_active      = n_hint;
    assign o_result.shutdown_request = n_shutdown;

endmodule

`default_nettype wire

>>> hw/rtl/debounced_long_press_button.sv
// Debounced power button with a red power-off hint and a long-press shutdown
// request. Each item on i_in is either a one millisecond tick carrying the raw
// button level (func 0) or a new status colour (func 1); every item produces
// exactly one result on o_out with the LED colour, the hint flag and the
// shutdown flag as they stand after that item. The block takes one item per
// clock cycle in steady state while o_out takes each result. An accepted item
// sits in an input register, and the state update runs in a single pass from
// there into the result register, which offers the result on o_out. The
// input register keeps accepting while a finished result waits on o_out; input
// stalls only when both registers are full. Configuration writes through
// i_cfg_we, i_cfg_idx and i_cfg_data act on the next item and must only be
// made while no item is in flight. All timers are TIME_WIDTH bits wide and
// saturate at all ones.
`default_nettype none

module debounced_long_press_button
    import dlpb_pkg::*;
#(
    parameter int TIME_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    dlpb_in_if.sink              i_in,
    dlpb_out_if.source           o_out
);

    t_cfg    cfg;
    t_result result;

    // Input register.
    logic  r_in_valid;
    t_item r_in_item;

    // Result register.
    logic    r_out_valid;
    t_result r_out;

    logic advance;
    logic fire;

    // The state stage moves whenever the result register is empty or drains now.
    assign advance = !r_out_valid || o_out.ready;
    assign fire    = r_in_valid && advance;

    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item.func         <= i_in.func;
            r_in_item.button_level <= i_in.button_level;
            r_in_item.colour       <= {i_in.red_on, i_in.green_on, i_in.blue_on};
        end
    end

    dlpb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    dlpb_state #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.led_red          = r_out.colour[2];
    assign o_out.led_green        = r_out.colour[1];
    assign o_out.led_blue         = r_out.colour[0];
    assign o_out.hint_active      = r_out.hint_active;
    assign o_out.shutdown_request = r_out.shutdown_request;

endmodule

`default_nettype wire

>>> hw/rtl/dlpb_checker.sv
`default_nettype none

module dlpb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_led_red,
    input logic i_led_green,
    input logic i_led_blue,
    input logic i_hint_active,
    input logic i_shutdown_request
);

    logic out_accept;
    logic r_seen_shutdown;

    assign out_accept = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_shutdown <= 1'b0;
        end else if (out_accept && i_shutdown_request) begin
            r_seen_shutdown <= 1'b1;
        end
    end

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // Shutdown latches until reset.
    a_shutdown_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen_shutdown && i_out_valid) |-> i_shutdown_request)
        else $error("shutdown request cleared without reset");

    // After shutdown the LED is dark.
    a_shutdown_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_shutdown_request) |->
            (!i_led_red && !i_led_green && !i_led_blue))
        else $error("LED lit while shutdown is requested");

    // Without a shutdown, the hint shows solid red only.
    a_hint_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_hint_active && !i_shutdown_request) |->
            (i_led_red && !i_led_green && !i_led_blue))
        else $error("hint shown with a colour other than red");

endmodule

bind debounced_long_press_button dlpb_checker u_dlpb_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_led_red          (o_out.led_red),
    .i_led_green        (o_out.led_green),
    .i_led_blue         (o_out.led_blue),
    .i_hint_active      (o_out.hint_active),
    .i_shutdown_request (o_out.shutdown_request)
);

`default_nettype wire

>>> bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dlpb_pkg::*;

    // The timers of the block under test are built at this width, and the
    // checker keeps its own timers at the same width so that saturation lines up.
    localparam int TW = 16;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 12;
    // Any cycle with neither an item nor a result accepted counts toward this
    // limit. The longest honest quiet stretch is a register reload after a
    // drain, so this leaves a wide margin.
    localparam int QUIET_LIMIT = 2000;
    // An item passes the input register and then the result register, so these
    // extra cycles after the last result are enough to be sure it is empty.
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_IDLE = 14;
    localparam int N_REGS = 5;
    localparam int N_PHASES = 7;
    localparam int MAX_REPORTS = 10;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    // One line of the directed table. It is either a register write or an
    // item. An item may carry a result typed in by hand.
    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        t_item                it;
        bit                   typed;
        t_result              want;
    } t_stim_row;

    // Internal state of the button, kept here so that the checker can work
    // out each LED result on its own.
    typedef struct {
        logic          last_level;
        logic [TW-1:0] since_edge;
        logic          pressed;
        logic [TW-1:0] held;
        logic          hint;
        logic [TW-1:0] since_reset;
        logic          shut;
        logic [2:0]    status;
        logic [2:0]    shown;
    } t_button_state;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    dlpb_in_if  in_if ();
    dlpb_out_if out_if ();

    debounced_long_press_button #(
        .TIME_WIDTH(TW)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    t_button_state btn;
    t_cfg          btn_cfg;
    t_result       pending_leds[$];
    t_stim_row     directed_rows[$];

    // When a side is calm it does not idle at all; the stimulus flips these
    // now and then so that long bursts and heavy idling both occur.
    bit src_calm;
    bit snk_calm;

    int n_sent;
    int n_checked;
    int n_fail;
    int n_hint_seen;
    int n_shut_seen;
    int n_settings;

    always begin
        i_clk = 1'b0;
        #(HALF_PERIOD);
        i_clk = 1'b1;
        #(HALF_PERIOD);
    end

    // Saturating increment of a timer.
    function automatic logic [TW-1:0] sat_up(input logic [TW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Limits a threshold to a length that a burst of ticks can reasonably
    // cover, so that huge settings still produce short, sensible bursts.
    function automatic int clip(input logic [CFG_W-1:0] v);
        return (v > 20) ? 20 : int'(v);
    endfunction

    function automatic t_cfg mk_cfg(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hint,
                                    input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] lock,
                                    input logic woke);
        t_cfg c;
        c.debounce_ms     = deb;
        c.hint_ms         = hint;
        c.long_press_ms   = lp;
        c.wake_lockout_ms = lock;
        c.woke_from_sleep = woke;
        return c;
    endfunction

    function automatic t_stim_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
        t_stim_row r;
        r.kind  = ROW_REG;
        r.idx   = idx;
        r.data  = data;
        r.it    = '0;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic t_stim_row item_row(input logic func, input logic level,
                                           input logic [2:0] colour);
        t_stim_row r;
        r.kind            = ROW_ITEM;
        r.idx             = '0;
        r.data            = '0;
        r.it.func         = func;
        r.it.button_level = level;
        r.it.colour       = colour;
        r.typed           = 1'b0;
        r.want            = '0;
        return r;
    endfunction

    function automatic t_stim_row checked_row(input logic func, input logic level,
                                              input logic [2:0] colour, input t_result want);
        t_stim_row r;
        r       = item_row(func, level, colour);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // Works out the LED result of one item and moves the button state on.
    // A set-colour item only stores the colour, and shows it when neither the
    // hint nor a shutdown owns the LED. Until a shutdown, a tick first runs the
    // three timers, then waits out the debounce time and the wake lockout, and
    // only then acts on a press or a release.
    function automatic t_result predict_led(input t_item it);
        t_result r;
        if (it.func == FUNC_SET_COLOUR) begin
            btn.status = it.colour;
            if (!btn.shut && !btn.hint) begin
                btn.shown = it.colour;
            end
        end else if (!btn.shut) begin
            btn.since_reset = sat_up(btn.since_reset);
            if (it.button_level != btn.last_level) begin
                btn.last_level = it.button_level;
                btn.since_edge = '0;
            end else begin
                btn.since_edge = sat_up(btn.since_edge);
            end
            if (btn.pressed) begin
                btn.held = sat_up(btn.held);
            end
            if (btn.since_edge >= btn_cfg.debounce_ms) begin
                if (btn_cfg.woke_from_sleep && btn.since_reset < btn_cfg.wake_lockout_ms) begin
                    // During the lockout the button is forgotten, but a hint
                    // that is already up stays up.
                    btn.pressed = 1'b0;
                end else begin
                    if (it.button_level && !btn.pressed) begin
                        btn.pressed = 1'b1;
                        btn.held    = '0;
                        if (btn.hint) begin
                            btn.hint  = 1'b0;
                            btn.shown = btn.status;
                        end
                    end else if (!it.button_level && btn.pressed) begin
                        btn.pressed = 1'b0;
                    end
                    if (btn.pressed) begin
                        if (!btn.hint && btn.held >= btn_cfg.hint_ms) begin
                            btn.hint  = 1'b1;
                            btn.shown = COLOUR_RED;
                        end
                        // With both thresholds at zero this follows the hint
                        // on the same tick, and the LED ends up dark.
                        if (btn.held >= btn_cfg.long_press_ms) begin
                            btn.shut  = 1'b1;
                            btn.shown = COLOUR_OFF;
                        end
                    end else if (btn.hint) begin
                        btn.hint  = 1'b0;
                        btn.shown = btn.status;
                    end
                end
            end
        end
        r.colour           = btn.shown;
        r.hint_active      = btn.hint;
        r.shutdown_request = btn.shut;
        return r;
    endfunction

    task automatic flag(input string msg);
        n_fail++;
        if (n_fail <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // Sends one item after a random gap and, once the block takes it, files
    // the result it should produce. A hand-typed result replaces the computed
    // one, but the state is always moved on.
    task automatic put_item(input t_item it, input bit typed, input t_result want);
        int      gap;
        t_result calc;
        gap = src_calm ? 0 : $urandom_range(0, MAX_IDLE);
        @(negedge i_clk);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.func         <= it.func;
        in_if.button_level <= it.button_level;
        in_if.red_on       <= it.colour[2];
        in_if.green_on     <= it.colour[1];
        in_if.blue_on      <= it.colour[0];
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        calc = predict_led(it);
        pending_leds.push_back(typed ? want : calc);
        n_sent++;
    endtask

    // Stops sending and waits until every pending result has come out, plus
    // a few cycles so that nothing is left inside the block.
    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_leds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_IDX_DEBOUNCE:   btn_cfg.debounce_ms     = data;
            CFG_IDX_HINT:       btn_cfg.hint_ms         = data;
            CFG_IDX_LONG_PRESS: btn_cfg.long_press_ms   = data;
            CFG_IDX_WAKE_LOCK:  btn_cfg.wake_lockout_ms = data;
            CFG_IDX_WOKE:       btn_cfg.woke_from_sleep = data[0];
            default:            ;
        endcase
    endtask

    // Loads a whole setting once the block is idle. The wake flag goes in
    // with random upper bits, which the block must drop, and one write to an
    // unused index must change nothing.
    task automatic program_regs(input t_cfg c);
        drain();
        write_reg(CFG_IDX_DEBOUNCE, c.debounce_ms);
        write_reg(CFG_IDX_HINT, c.hint_ms);
        write_reg(CFG_IDX_LONG_PRESS, c.long_press_ms);
        write_reg(CFG_IDX_WAKE_LOCK, c.wake_lockout_ms);
        write_reg(CFG_IDX_WOKE, {15'($urandom), c.woke_from_sleep});
        write_reg(CFG_IDX_W'($urandom_range(N_REGS, (1 << CFG_IDX_W) - 1)), 16'($urandom));
        n_settings++;
    endtask

    // One item at the given button level. Now and then a set-colour item is
    // slipped in instead, and the fields that an item does not use get
    // random values.
    task automatic feed(input logic level);
        t_item it;
        it.func         = ($urandom_range(0, 7) == 0) ? FUNC_SET_COLOUR : FUNC_TICK;
        it.button_level = level;
        it.colour       = 3'($urandom_range(0, 7));
        put_item(it, 1'b0, '0);
    endtask

    // A whole press: some contact bounce, a hold long enough to reach the
    // hint at times, bounce on release, and a rest. The lengths follow the
    // current thresholds so that most presses make it past the debounce.
    task automatic run_press();
        int deb_c;
        int hint_c;
        deb_c  = clip(btn_cfg.debounce_ms);
        hint_c = clip(btn_cfg.hint_ms);
        repeat ($urandom_range(0, 3)) begin
            repeat ($urandom_range(1, deb_c + 1)) feed(1'b1);
            repeat ($urandom_range(1, deb_c + 1)) feed(1'b0);
        end
        repeat ($urandom_range(1, deb_c + hint_c + 6)) feed(1'b1);
        repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(1, deb_c + 1)) feed(1'b0);
            repeat ($urandom_range(1, deb_c + 1)) feed(1'b1);
        end
        repeat ($urandom_range(1, deb_c + 6)) feed(1'b0);
    endtask

    // Result side: stalls for a random number of cycles before each result,
    // or not at all while calm.
    initial begin : led_sink
        int stall;
        out_if.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = snk_calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
                @(negedge i_clk);
                out_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (out_if.valid !== 1'b1) @(posedge i_clk);
        end
    end

    // Every result is held against the oldest pending one, field by field.
    always @(posedge i_clk) begin : led_check
        t_result got;
        t_result exp;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.colour           = {out_if.led_red, out_if.led_green, out_if.led_blue};
            got.hint_active      = out_if.hint_active;
            got.shutdown_request = out_if.shutdown_request;
            n_checked++;
            if (got.hint_active === 1'b1) n_hint_seen++;
            if (got.shutdown_request === 1'b1) n_shut_seen++;
            if (pending_leds.size() == 0) begin
                flag($sformatf("result %0d came with none pending: rgb=%b hint=%b shut=%b",
                               n_checked, got.colour, got.hint_active, got.shutdown_request));
            end else begin
                exp = pending_leds.pop_front();
                if (got.colour[2] !== exp.colour[2] || got.colour[1] !== exp.colour[1] ||
                    got.colour[0] !== exp.colour[0] ||
                    got.hint_active !== exp.hint_active ||
                    got.shutdown_request !== exp.shutdown_request) begin
                    flag($sformatf({"result %0d mismatch: want rgb=%b hint=%b shut=%b, ",
                                    "got rgb=%b hint=%b shut=%b"},
                                   n_checked, exp.colour, exp.hint_active,
                                   exp.shutdown_request, got.colour, got.hint_active,
                                   got.shutdown_request));
                end
            end
        end
    end

    // Ends the run when nothing has moved on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int        k;
        int        ph;
        int        pick;
        int        stop_at;
        t_cfg      c;
        t_stim_row row;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        in_if.valid        = 1'b0;
        in_if.func         = FUNC_TICK;
        in_if.button_level = 1'b0;
        in_if.red_on       = 1'b0;
        in_if.green_on     = 1'b0;
        in_if.blue_on      = 1'b0;
        src_calm           = 1'b0;
        snk_calm           = 1'b0;
        n_sent             = 0;
        n_checked          = 0;
        n_fail             = 0;
        n_hint_seen        = 0;
        n_shut_seen        = 0;
        n_settings         = 1;

        // The checker starts from the same state as the block after reset.
        btn.last_level          = 1'b0;
        btn.since_edge          = '1;
        btn.pressed             = 1'b0;
        btn.held                = '0;
        btn.hint                = 1'b0;
        btn.since_reset         = '0;
        btn.shut                = 1'b0;
        btn.status              = COLOUR_OFF;
        btn.shown               = COLOUR_OFF;
        btn_cfg.debounce_ms     = RST_DEBOUNCE_MS;
        btn_cfg.hint_ms         = RST_HINT_MS;
        btn_cfg.long_press_ms   = RST_LONG_PRESS_MS;
        btn_cfg.wake_lockout_ms = RST_WAKE_LOCK_MS;
        btn_cfg.woke_from_sleep = 1'b0;

        // Directed table. The first rows run with the reset settings: a
        // colour shows at once, and a steady released button leaves it alone
        // while the colour fields of a tick are ignored.
        directed_rows.push_back(checked_row(FUNC_SET_COLOUR, 1'b1, 3'b011, {3'b011, 1'b0, 1'b0}));
        directed_rows.push_back(checked_row(FUNC_TICK, 1'b0, 3'b111, {3'b011, 1'b0, 1'b0}));
        directed_rows.push_back(item_row(FUNC_TICK, 1'b1, 3'b000));
        // Writes to unused indexes must be ignored.
        directed_rows.push_back(reg_row(CFG_IDX_W'(N_REGS), '1));
        directed_rows.push_back(reg_row('1, 16'h1234));
        // No debounce, a short hint, no reachable shutdown, and a short wake
        // lockout. The wake flag is written with all bits set.
        directed_rows.push_back(reg_row(CFG_IDX_DEBOUNCE, '0));
        directed_rows.push_back(reg_row(CFG_IDX_HINT, 16'd2));
        directed_rows.push_back(reg_row(CFG_IDX_LONG_PRESS, '1));
        directed_rows.push_back(reg_row(CFG_IDX_WAKE_LOCK, 16'd6));
        directed_rows.push_back(reg_row(CFG_IDX_WOKE, '1));
        // Three presses fall inside the lockout, then the press counts and
        // the hint comes up two ticks later.
        for (k = 0; k < 6; k++) begin
            directed_rows.push_back(item_row(FUNC_TICK, 1'b1, 3'($urandom_range(0, 7))));
        end
        // A new colour during the hint is stored but not shown.
        directed_rows.push_back(item_row(FUNC_SET_COLOUR, 1'b0, 3'b110));
        // A release inside a long lockout leaves the hint up; the next press
        // after the lockout must take it down and show the stored colour.
        directed_rows.push_back(reg_row(CFG_IDX_WAKE_LOCK, '1));
        directed_rows.push_back(item_row(FUNC_TICK, 1'b0, 3'b101));
        directed_rows.push_back(reg_row(CFG_IDX_WAKE_LOCK, '0));
        directed_rows.push_back(item_row(FUNC_TICK, 1'b1, 3'b010));
        directed_rows.push_back(item_row(FUNC_TICK, 1'b0, 3'b001));
        // The longest debounce holds everything back; a zero hint then
        // lights red on the very tick of the press.
        directed_rows.push_back(reg_row(CFG_IDX_HINT, '0));
        directed_rows.push_back(reg_row(CFG_IDX_DEBOUNCE, '1));
        directed_rows.push_back(item_row(FUNC_TICK, 1'b1, 3'b111));
        directed_rows.push_back(item_row(FUNC_TICK, 1'b1, 3'b000));
        directed_rows.push_back(reg_row(CFG_IDX_DEBOUNCE, '0));
        directed_rows.push_back(item_row(FUNC_TICK, 1'b1, 3'b100));
        directed_rows.push_back(item_row(FUNC_TICK, 1'b0, 3'b011));
        directed_rows.push_back(item_row(FUNC_SET_COLOUR, 1'b1, 3'b000));
        directed_rows.push_back(item_row(FUNC_SET_COLOUR, 1'b0, 3'b111));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_REG) begin
                drain();
                write_reg(row.idx, row.data);
            end else begin
                put_item(row.it, row.typed, row.want);
            end
        end

        // Random part. Each phase loads its own setting and then plays
        // mostly whole presses, with bursts of arbitrary items as noise. The
        // long-press time stays out of reach so the run is never cut short
        // by a shutdown, which only a reset could clear.
        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       c = mk_cfg(16'd2, 16'd6, '1, '0, 1'b1);
                1:       c = mk_cfg('0, '0, '1, '0, 1'b0);
                2:       c = mk_cfg('1, 16'd3, '1, '0, 1'b0);
                3:       c = mk_cfg(16'd4, '1, '1, '1, 1'b0);
                4:       c = mk_cfg(16'd1, 16'd10, '1, '1, 1'b1);
                // The lockout runs out partway through this phase.
                5:       c = mk_cfg(16'd3, 16'd12, '1, btn.since_reset + 16'd40, 1'b1);
                default: c = mk_cfg(16'($urandom_range(0, 3)), 16'($urandom_range(0, 12)), '1,
                                    btn.since_reset + 16'($urandom_range(0, 60)),
                                    1'($urandom_range(0, 1)));
            endcase
            program_regs(c);
            // Nothing settles under the longest debounce, so that phase is kept short.
            stop_at = n_sent + ((ph == 2) ? 50 : 90);
            while (n_sent < stop_at) begin
                if ($urandom_range(0, 9) == 0) begin
                    src_calm = ($urandom_range(0, 2) == 0);
                    snk_calm = ($urandom_range(0, 2) == 0);
                end
                if ($urandom_range(0, 29) == 0) begin
                    drain();
                end
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    run_press();
                end else if (pick < 9) begin
                    repeat ($urandom_range(1, 6))
                        put_item(t_item'(5'($urandom_range(0, 31))), 1'b0, '0);
                end else begin
                    feed(1'($urandom_range(0, 1)));
                end
            end
        end

        // Closing part: with both thresholds at zero a fresh press raises the
        // hint and the shutdown on one tick and leaves the LED dark. After
        // that ticks do nothing and colours are only stored.
        program_regs(mk_cfg('0, '0, '0, '0, 1'b0));
        put_item(t_item'({FUNC_TICK, 1'b0, 3'b101}), 1'b0, '0);
        put_item(t_item'({FUNC_TICK, 1'b1, 3'b010}), 1'b1, {COLOUR_OFF, 1'b1, 1'b1});
        repeat (30) put_item(t_item'(5'($urandom_range(0, 31))), 1'b0, '0);

        drain();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d items under %0d register settings, checked %0d results.",
                 n_sent, n_settings, n_checked);
        $display("Results with the hint up: %0d, with shutdown latched: %0d, failures: %0d.",
                 n_hint_seen, n_shut_seen, n_fail);
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/dlpb_pkg.sv
hw/rtl/dlpb_in_if.sv
hw/rtl/dlpb_out_if.sv
hw/rtl/dlpb_cfg_regs.sv
hw/rtl/dlpb_state.sv
hw/rtl/debounced_long_press_button.sv
hw/rtl/dlpb_checker.sv
bench/tb.sv
